[rtl/api_frame_receiver_defines.svh]
// Assertion macros used by the checker of the frame receiver.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef API_FRAME_RECEIVER_DEFINES_SVH
`define API_FRAME_RECEIVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/afr_pkg.sv]
`default_nettype none

package afr_pkg;

  // Frame delimiters and type codes
  localparam logic [7:0] START_BYTE     = 8'h7e;
  localparam logic [7:0] TX_STATUS_TYPE = 8'h8b;

  // Outcome code carried with every result beat
  typedef enum logic [1:0] {
    OUTCOME_GOOD       = 2'd0,
    OUTCOME_CHECKSUM   = 2'd1,
    OUTCOME_OVERRUN    = 2'd2,
    OUTCOME_LINE_ABORT = 2'd3
  } outcome_t;

  // One result beat as produced by the parser
  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  frame_type;
    logic [15:0] frame_len;
    logic [31:0] retry_total;
    logic [31:0] lost_total;
    logic [31:0] unknown_total;
    logic [31:0] checksum_error_total;
    logic [31:0] overrun_total;
    logic [31:0] error_total;
    logic [31:0] skipped_total;
  } afr_result_t;

endpackage

`default_nettype wire

[rtl/afr_parser.sv]
`default_nettype none

module afr_parser #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 advance,
  input  wire  [7:0]          rx_byte,
  input  wire                 line_error,
  output logic                res_valid,
  output afr_pkg::afr_result_t res
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  localparam logic [16:0] MaxLen    = 17'(BUFFER_BYTES - 1);
  localparam logic [15:0] PosType   = 16'd0;
  localparam logic [15:0] PosRetry  = 16'd4;
  localparam logic [15:0] PosStatus = 16'd5;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [31:0] retry_tot_r, retry_tot_nxt;
  logic [31:0] lost_tot_r, lost_tot_nxt;
  logic [31:0] unknown_tot_r, unknown_tot_nxt;
  logic [31:0] cksum_tot_r, cksum_tot_nxt;
  logic [31:0] overrun_tot_r, overrun_tot_nxt;
  logic [31:0] error_tot_r, error_tot_nxt;
  logic [31:0] skipped_tot_r, skipped_tot_nxt;

  logic [15:0]       len_full;
  afr_pkg::outcome_t res_outcome;
  logic [7:0]        res_type;
  logic [15:0]       res_len;

  assign len_full = {len_r[15:8], rx_byte};

  // Work out next state and the result for the byte at the input
  always_comb begin
    phase_nxt       = phase_r;
    len_nxt         = len_r;
    count_nxt       = count_r;
    sum_nxt         = sum_r;
    type_nxt        = type_r;
    retries_nxt     = retries_r;
    status_nxt      = status_r;
    retry_tot_nxt   = retry_tot_r;
    lost_tot_nxt    = lost_tot_r;
    unknown_tot_nxt = unknown_tot_r;
    cksum_tot_nxt   = cksum_tot_r;
    overrun_tot_nxt = overrun_tot_r;
    error_tot_nxt   = error_tot_r;
    skipped_tot_nxt = skipped_tot_r;
    res_valid       = 1'b0;
    res_outcome     = afr_pkg::OUTCOME_GOOD;
    res_type        = 8'h00;
    res_len         = 16'h0000;

    if (line_error) begin
      // Abort from any phase
      error_tot_nxt = error_tot_r + 32'd1;
      phase_nxt     = PH_IDLE;
      res_valid     = 1'b1;
      res_outcome   = afr_pkg::OUTCOME_LINE_ABORT;
      res_len       = (phase_r == PH_IDLE) ? 16'h0000 : len_r;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          // Hunt for the start byte, count everything else as skipped
          if (rx_byte != afr_pkg::START_BYTE) begin
            skipped_tot_nxt = skipped_tot_r + 32'd1;
          end else begin
            len_nxt   = 16'h0000;
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_nxt   = {rx_byte, 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt = len_full;
          if ({1'b0, len_full} > MaxLen) begin
            // Drop a frame that does not fit the buffer
            overrun_tot_nxt = overrun_tot_r + 32'd1;
            error_tot_nxt   = error_tot_r + 32'd1;
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
            res_outcome     = afr_pkg::OUTCOME_OVERRUN;
            res_len         = len_full;
          end else begin
            count_nxt   = 16'h0000;
            sum_nxt     = 8'h00;
            type_nxt    = 8'h00;
            retries_nxt = 8'h00;
            status_nxt  = 8'h00;
            phase_nxt   = PH_DATA;
          end
        end
        PH_DATA: begin
          if (count_r != len_r) begin
            // Accumulate a data byte and capture the fields we care about
            sum_nxt   = sum_r + rx_byte;
            count_nxt = count_r + 16'd1;
            if (count_r == PosType) begin
              type_nxt = rx_byte;
            end
            if (count_r == PosRetry) begin
              retries_nxt = rx_byte;
            end
            if (count_r == PosStatus) begin
              status_nxt = rx_byte;
            end
          end else begin
            // Checksum byte: verify, then handle the frame by type
            res_outcome = afr_pkg::OUTCOME_GOOD;
            if (rx_byte != ~sum_r) begin
              cksum_tot_nxt = cksum_tot_r + 32'd1;
              res_outcome   = afr_pkg::OUTCOME_CHECKSUM;
            end
            if ((len_r != 16'h0000) && (type_r == afr_pkg::TX_STATUS_TYPE)) begin
              retry_tot_nxt = retry_tot_r + {24'h000000, retries_r};
              if (status_r != 8'h00) begin
                lost_tot_nxt = lost_tot_r + 32'd1;
              end
            end else begin
              unknown_tot_nxt = unknown_tot_r + 32'd1;
            end
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_type  = (len_r != 16'h0000) ? type_r : 8'h00;
            res_len   = len_r;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result beat carries the counters after this byte
  always_comb begin
    res.outcome              = res_outcome;
    res.frame_type           = res_type;
    res.frame_len            = res_len;
    res.retry_total          = retry_tot_nxt;
    res.lost_total           = lost_tot_nxt;
    res.unknown_total        = unknown_tot_nxt;
    res.checksum_error_total = cksum_tot_nxt;
    res.overrun_total        = overrun_tot_nxt;
    res.error_total          = error_tot_nxt;
    res.skipped_total        = skipped_tot_nxt;
  end

  // Advance state on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      len_r         <= 16'h0000;
      count_r       <= 16'h0000;
      sum_r         <= 8'h00;
      type_r        <= 8'h00;
      retries_r     <= 8'h00;
      status_r      <= 8'h00;
      retry_tot_r   <= 32'd0;
      lost_tot_r    <= 32'd0;
      unknown_tot_r <= 32'd0;
      cksum_tot_r   <= 32'd0;
      overrun_tot_r <= 32'd0;
      error_tot_r   <= 32'd0;
      skipped_tot_r <= 32'd0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      len_r         <= len_nxt;
      count_r       <= count_nxt;
      sum_r         <= sum_nxt;
      type_r        <= type_nxt;
      retries_r     <= retries_nxt;
      status_r      <= status_nxt;
      retry_tot_r   <= retry_tot_nxt;
      lost_tot_r    <= lost_tot_nxt;
      unknown_tot_r <= unknown_tot_nxt;
      cksum_tot_r   <= cksum_tot_nxt;
      overrun_tot_r <= overrun_tot_nxt;
      error_tot_r   <= error_tot_nxt;
      skipped_tot_r <= skipped_tot_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/api_frame_receiver.sv]
// Frame receiver: takes one serial byte per beat with its line-error flag,
// hunts for the 0x7e start byte, reads a big-endian 16-bit length, sums the
// data bytes and checks the trailing checksum. A result beat comes out at
// the end of each frame, on a length above BUFFER_BYTES - 1, and on any
// line error; it carries the outcome, frame type and length, and the seven
// wrapping 32-bit event counters as they stand after that byte. The parser
// handles each byte in the cycle it is accepted, so one byte is accepted per
// clock unless the input stalls; results are registered and appear in the
// cycle after the byte that ends the frame. The input stalls only while the
// output register holds a result beat that out_ready has not taken.
`default_nettype none

module api_frame_receiver #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_rx_byte,
  input  wire         in_line_error,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_frame_type,
  output logic [15:0] out_frame_len,
  output logic [31:0] out_retry_total,
  output logic [31:0] out_lost_total,
  output logic [31:0] out_unknown_total,
  output logic [31:0] out_checksum_error_total,
  output logic [31:0] out_overrun_total,
  output logic [31:0] out_error_total,
  output logic [31:0] out_skipped_total
);

  logic                 advance;
  logic                 res_valid;
  afr_pkg::afr_result_t res;
  logic                 out_valid_r;
  afr_pkg::afr_result_t out_data_r;

  // Accept while the result register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign advance  = in_valid && in_ready;

  afr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rx_byte   (in_rx_byte),
    .line_error(in_line_error),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_outcome              = out_data_r.outcome;
  assign out_frame_type           = out_data_r.frame_type;
  assign out_frame_len            = out_data_r.frame_len;
  assign out_retry_total          = out_data_r.retry_total;
  assign out_lost_total           = out_data_r.lost_total;
  assign out_unknown_total        = out_data_r.unknown_total;
  assign out_checksum_error_total = out_data_r.checksum_error_total;
  assign out_overrun_total        = out_data_r.overrun_total;
  assign out_error_total          = out_data_r.error_total;
  assign out_skipped_total        = out_data_r.skipped_total;

endmodule

`default_nettype wire

[rtl/afr_checker.sv]
`default_nettype none
`include "api_frame_receiver_defines.svh"

module afr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_line_error,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_outcome,
  input wire [7:0]  out_frame_type,
  input wire [15:0] out_frame_len,
  input wire [31:0] out_error_total
);

  // An empty result register never blocks the input
  `AFR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // A line error always yields an abort beat right after acceptance
  `AFR_ASSERT_NEXT(a_line_abort, in_valid && in_ready && in_line_error,
    out_valid && (out_outcome == afr_pkg::OUTCOME_LINE_ABORT))

  // Aborted or overrun frames report no type
  `AFR_ASSERT_NOW(a_no_type_on_error, out_valid &&
    ((out_outcome == afr_pkg::OUTCOME_OVERRUN) ||
     (out_outcome == afr_pkg::OUTCOME_LINE_ABORT)), out_frame_type == 8'h00)

  // A stalled result beat holds
  `AFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_error_total) && $stable(out_frame_len))

endmodule

bind api_frame_receiver afr_checker u_afr_checker (.*);

`default_nettype wire
